// ----- sv/tmcs_pkg.sv -----
// shared constants for the texture mip chain size calculator
// format codes, per-format byte counts and the width of the shared multiplier
// no dependencies
package tmcs_pkg;

    localparam int MAX_DIM_DEF    = 16384;
    localparam int MAX_LEVELS_DEF = 15;

    // operand a width: a 32-bit value plus one saturation bit
    localparam int A_W = 33;

    localparam logic [3:0] FMT_DXT1 = 4'd12;
    localparam logic [3:0] FMT_DXT3 = 4'd13;
    localparam logic [3:0] FMT_DXT5 = 4'd14;
    localparam logic [3:0] FMT_ETC1 = 4'd15;

    localparam logic [A_W-1:0] SAT_LIM = 33'h1_0000_0000;

    // bytes per texel, or per 4x4 block for compressed formats
    function automatic logic [4:0] unit_bytes(input logic [3:0] fmt);
        logic [4:0] ub;
        case (fmt)
            4'd0:    ub = 5'd1;
            4'd1:    ub = 5'd2;
            4'd2:    ub = 5'd3;
            4'd3:    ub = 5'd4;
            4'd4:    ub = 5'd2;
            4'd5:    ub = 5'd4;
            4'd6:    ub = 5'd6;
            4'd7:    ub = 5'd8;
            4'd8:    ub = 5'd4;
            4'd9:    ub = 5'd8;
            4'd10:   ub = 5'd12;
            4'd11:   ub = 5'd16;
            4'd12:   ub = 5'd8;
            4'd13:   ub = 5'd16;
            4'd14:   ub = 5'd16;
            default: ub = 5'd8;
        endcase
        return ub;
    endfunction

endpackage

// ----- sv/tmcs_mul.sv -----
// shared multiplier of the mip chain size calculator
// gives the full product and a copy saturated at 2^32
// depends on tmcs_pkg
module tmcs_mul #(
    parameter int B_W = 17
) (
    input  logic [tmcs_pkg::A_W-1:0]     i_a,
    input  logic [B_W-1:0]               i_b,
    output logic [tmcs_pkg::A_W+B_W-1:0] o_prod,
    output logic [tmcs_pkg::A_W-1:0]     o_sat
);

    localparam int P_W = tmcs_pkg::A_W + B_W;

    assign o_prod = P_W'(i_a) * P_W'(i_b);
    assign o_sat  = (o_prod >= P_W'(tmcs_pkg::SAT_LIM)) ? tmcs_pkg::SAT_LIM
                                                         : o_prod[tmcs_pkg::A_W-1:0];

endmodule

// ----- sv/texture_mip_chain_size_calc.sv -----
// top level of the texture mip chain size calculator
// sequences one shared multiplier over the mip levels and the final products
// depends on tmcs_pkg and tmcs_mul
//
// One item at a time: after an item is accepted, the block forms one product per
// mip level in a pipelined multiply and accumulate (levels capped at MAX_LEVELS),
// then uses the same multiplier in turn for the depth and byte scaling of the
// chain size, the slice pitch and the row pitch, and then holds the result until
// it is taken. Ready is high only while no item is in work. Results above 32 bits
// read as all ones with overflow set.
module texture_mip_chain_size_calc #(
    parameter int MAX_DIM    = tmcs_pkg::MAX_DIM_DEF,
    parameter int MAX_LEVELS = tmcs_pkg::MAX_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_format,
    input  logic [14:0] i_width,
    input  logic [14:0] i_height,
    input  logic [11:0] i_depth,
    input  logic [3:0]  i_levels,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_total_size,
    output logic [18:0] o_row_pitch,
    output logic [31:0] o_slice_pitch,
    output logic        o_overflow
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int LV_W   = $clog2(MAX_LEVELS + 1);
    localparam int PROD_W = 2 * DIM_W;
    localparam int ACC_W  = 2 * DIM_W + 5;
    localparam int B_W    = (DIM_W > 12) ? DIM_W : 12;
    localparam int A_W    = tmcs_pkg::A_W;
    localparam int P_W    = A_W + B_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LVL  = 4'd1;
    localparam logic [3:0] S_MD   = 4'd2;
    localparam logic [3:0] S_MU   = 4'd3;
    localparam logic [3:0] S_MWH  = 4'd4;
    localparam logic [3:0] S_MUS  = 4'd5;
    localparam logic [3:0] S_ROW  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]       r_state, n_state;
    logic [3:0]       r_fmt;
    logic [DIM_W-1:0] r_wraw, r_hraw, r_w, r_h;
    logic [11:0]      r_d;
    logic [LV_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_prod;
    logic             r_pv;
    logic [ACC_W-1:0] r_acc;
    logic [A_W-1:0]   r_t, r_s;
    logic [18:0]      r_row;

    logic [DIM_W-1:0] w_cl, h_cl;
    logic [LV_W-1:0]  lv_cl;
    logic             compressed;
    logic [4:0]       ub;
    logic [DIM_W:0]   w_up, h_up;
    logic [DIM_W-1:0] w_lv, h_lv, wq, hq;
    logic [ACC_W-1:0] term;
    logic [A_W-1:0]   acc_sat;
    logic [A_W-1:0]   mul_a;
    logic [B_W-1:0]   mul_b;
    logic [P_W-1:0]   mul_p;
    logic [A_W-1:0]   mul_s;

    assign w_cl  = (32'(i_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(i_width);
    assign h_cl  = (32'(i_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(i_height);
    assign lv_cl = (32'(i_levels) > MAX_LEVELS) ? LV_W'(MAX_LEVELS) : LV_W'(i_levels);

    assign compressed = (r_fmt >= tmcs_pkg::FMT_DXT1);
    assign ub         = tmcs_pkg::unit_bytes(r_fmt);

    assign w_up = ((DIM_W + 1)'(r_w) + (DIM_W + 1)'(3)) >> 2;
    assign h_up = ((DIM_W + 1)'(r_h) + (DIM_W + 1)'(3)) >> 2;
    assign w_lv = (compressed && r_fmt != tmcs_pkg::FMT_ETC1) ? DIM_W'(w_up) : r_w;
    assign h_lv = (compressed && r_fmt != tmcs_pkg::FMT_ETC1) ? DIM_W'(h_up) : r_h;
    assign wq   = compressed ? (r_wraw >> 2) : r_wraw;
    assign hq   = compressed ? (r_hraw >> 2) : r_hraw;

    always_comb begin
        if (r_fmt == tmcs_pkg::FMT_ETC1) begin
            term = ACC_W'(r_prod >> 1);
        end else if (compressed) begin
            term = (r_fmt == tmcs_pkg::FMT_DXT1) ? (ACC_W'(r_prod) << 3)
                                                 : (ACC_W'(r_prod) << 4);
        end else begin
            term = ACC_W'(r_prod);
        end
    end

    assign acc_sat = (64'(r_acc) > 64'(tmcs_pkg::SAT_LIM)) ? tmcs_pkg::SAT_LIM
                                                           : A_W'(r_acc);

    // operand selection for the shared multiplier
    always_comb begin
        case (r_state)
            S_LVL: begin
                mul_a = A_W'(w_lv);
                mul_b = B_W'(h_lv);
            end
            S_MD: begin
                mul_a = acc_sat;
                mul_b = B_W'(r_d);
            end
            S_MU: begin
                mul_a = r_t;
                mul_b = compressed ? B_W'(1) : B_W'(ub);
            end
            S_MWH: begin
                mul_a = A_W'(wq);
                mul_b = B_W'(hq);
            end
            S_MUS: begin
                mul_a = r_s;
                mul_b = B_W'(ub);
            end
            S_ROW: begin
                mul_a = A_W'(wq);
                mul_b = B_W'(ub);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tmcs_mul #(
        .B_W (B_W)
    ) u_mul (
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p),
        .o_sat  (mul_s)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_LVL;
            S_LVL:   if (r_cnt == '0 && !r_pv) n_state = S_MD;
            S_MD:    n_state = S_MU;
            S_MU:    n_state = S_MWH;
            S_MWH:   n_state = S_MUS;
            S_MUS:   n_state = S_ROW;
            S_ROW:   n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_fmt  <= i_format;
                        r_wraw <= w_cl;
                        r_hraw <= h_cl;
                        r_w    <= (w_cl == '0) ? DIM_W'(1) : w_cl;
                        r_h    <= (h_cl == '0) ? DIM_W'(1) : h_cl;
                        r_d    <= (i_depth == '0) ? 12'd1 : i_depth;
                        r_cnt  <= lv_cl;
                        r_acc  <= '0;
                        r_pv   <= 1'b0;
                    end
                end
                S_LVL: begin
                    if (r_pv) begin
                        r_acc <= r_acc + term;
                    end
                    if (r_cnt != '0) begin
                        r_prod <= mul_p[PROD_W-1:0];
                        r_pv   <= 1'b1;
                        r_cnt  <= r_cnt - LV_W'(1);
                        r_w    <= r_w >> 1;
                        r_h    <= r_h >> 1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                end
                S_MD:    r_t   <= mul_s;
                S_MU:    r_t   <= mul_s;
                S_MWH:   r_s   <= mul_s;
                S_MUS:   r_s   <= mul_s;
                S_ROW:   r_row <= mul_p[18:0];
                default: begin
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_total_size  = r_t[A_W-1] ? 32'hFFFF_FFFF : r_t[31:0];
    assign o_slice_pitch = r_s[A_W-1] ? 32'hFFFF_FFFF : r_s[31:0];
    assign o_row_pitch   = r_row;
    assign o_overflow    = r_t[A_W-1] | r_s[A_W-1];

endmodule
